/* src/agt_pkg.sv */
package agt_pkg;

  localparam int unsigned TrigStages = 16;
  localparam int unsigned NumRegs    = 7;

  localparam logic signed [17:0] Ofs2Q12 = 18'sd11078;
  localparam logic signed [17:0] Ofs3Q12 = 18'sd10437;
  localparam logic signed [17:0] Ofs4Q12 = 18'sd7327;

  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_GRAVITY = 3'd0,
    REG_MX2     = 3'd1,
    REG_MY2     = 3'd2,
    REG_MX3     = 3'd3,
    REG_MY3     = 3'd4,
    REG_MX4     = 3'd5,
    REG_MY4     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] angle_joint2;
    logic signed [15:0] angle_joint3;
    logic signed [15:0] angle_joint4;
  } agt_in_t;

  typedef struct packed {
    logic signed [31:0] torque_joint2;
    logic signed [31:0] torque_joint3;
    logic signed [31:0] torque_joint4;
  } agt_out_t;

  typedef struct packed {
    logic        [15:0] grav;
    logic signed [15:0] mx2;
    logic signed [15:0] my2;
    logic signed [15:0] mx3;
    logic signed [15:0] my3;
    logic signed [15:0] mx4;
    logic signed [15:0] my4;
  } agt_cfg_t;

  // cordic lane state: x, y in Q.30, residual angle in Q.28
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } agt_cdc_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q28 = 34'sd210828714;
      5'd1:  atan_q28 = 34'sd124459457;
      5'd2:  atan_q28 = 34'sd65760959;
      5'd3:  atan_q28 = 34'sd33381290;
      5'd4:  atan_q28 = 34'sd16755422;
      5'd5:  atan_q28 = 34'sd8385879;
      5'd6:  atan_q28 = 34'sd4193963;
      5'd7:  atan_q28 = 34'sd2097109;
      5'd8:  atan_q28 = 34'sd1048571;
      5'd9:  atan_q28 = 34'sd524287;
      5'd10: atan_q28 = 34'sd262144;
      5'd11: atan_q28 = 34'sd131072;
      5'd12: atan_q28 = 34'sd65536;
      5'd13: atan_q28 = 34'sd32768;
      5'd14: atan_q28 = 34'sd16384;
      5'd15: atan_q28 = 34'sd8192;
      5'd16: atan_q28 = 34'sd4096;
      5'd17: atan_q28 = 34'sd2048;
      5'd18: atan_q28 = 34'sd1024;
      5'd19: atan_q28 = 34'sd512;
      5'd20: atan_q28 = 34'sd256;
      5'd21: atan_q28 = 34'sd128;
      5'd22: atan_q28 = 34'sd64;
      5'd23: atan_q28 = 34'sd32;
      default: atan_q28 = 34'sd0;
    endcase
  endfunction

endpackage

/* src/agt_trig.sv */
// one sine/cosine lane: range reduction, then one cordic step per stage
module agt_trig import agt_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [17:0] arg_i,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);

  agt_cdc_t pipe_q [TrigStages+1];
  agt_cdc_t red_d;
  logic signed [33:0] a0, a1, a2;
  logic signed [33:0] xr, yr;

  always_comb begin
    // offset angle reaches past three half turns, so up to two turns come off
    a0 = {arg_i, 16'd0};
    if (a0 > PiQ28 + TwoPiQ28) a1 = a0 - TwoPiQ28 - TwoPiQ28;
    else if (a0 > PiQ28) a1 = a0 - TwoPiQ28;
    else if (a0 < -PiQ28) a1 = a0 + TwoPiQ28;
    else a1 = a0;
    a2 = a1;
    red_d.flip = 1'b0;
    if (a1 > HalfPiQ28) begin
      a2 = a1 - PiQ28;
      red_d.flip = 1'b1;
    end else if (a1 < -HalfPiQ28) begin
      a2 = a1 + PiQ28;
      red_d.flip = 1'b1;
    end
    red_d.x = GainQ30;
    red_d.y = '0;
    red_d.z = a2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pipe_q[0] <= red_d;
  end

  for (genvar i = 0; i < TrigStages; i++) begin : g_step
    agt_cdc_t nxt_d;
    always_comb begin
      nxt_d.flip = pipe_q[i].flip;
      if (!pipe_q[i].z[33]) begin
        nxt_d.x = pipe_q[i].x - (pipe_q[i].y >>> i);
        nxt_d.y = pipe_q[i].y + (pipe_q[i].x >>> i);
        nxt_d.z = pipe_q[i].z - atan_q28(5'(i));
      end else begin
        nxt_d.x = pipe_q[i].x + (pipe_q[i].y >>> i);
        nxt_d.y = pipe_q[i].y - (pipe_q[i].x >>> i);
        nxt_d.z = pipe_q[i].z + atan_q28(5'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) pipe_q[i+1] <= nxt_d;
    end
  end

  always_comb begin
    xr = (pipe_q[TrigStages].x + 34'sd8192) >>> 14;
    yr = (pipe_q[TrigStages].y + 34'sd8192) >>> 14;
    cos_o = pipe_q[TrigStages].flip ? -xr[17:0] : xr[17:0];
    sin_o = pipe_q[TrigStages].flip ? -yr[17:0] : yr[17:0];
  end

endmodule

/* src/agt_chain.sv */
// gravity vector rotation and torque sums, all stages registered
module agt_chain import agt_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  agt_cfg_t           cfg_i,
  input  logic signed [17:0] s2_i,
  input  logic signed [17:0] c2_i,
  input  logic signed [17:0] s3_i,
  input  logic signed [17:0] c3_i,
  input  logic signed [17:0] s4_i,
  input  logic signed [17:0] c4_i,
  output agt_out_t           out_o
);

  // stage a: vp12, vp22
  logic signed [35:0] vp12_q, vp22_q;
  logic signed [17:0] s3a_q, c3a_q, s4a_q, c4a_q;
  // stage b: products for joint 3 rotation
  logic signed [55:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [35:0] vp12b_q, vp22b_q;
  logic signed [17:0] s4b_q, c4b_q;
  // stage c: vp13, vp23
  logic signed [35:0] vp13_q, vp23_q, vp12c_q, vp22c_q;
  logic signed [17:0] s4c_q, c4c_q;
  // stage d: products for joint 4 rotation
  logic signed [55:0] r1_q, r2_q, r3_q, r4_q;
  logic signed [35:0] vp13d_q, vp23d_q, vp12d_q, vp22d_q;
  // stage e: vp14, vp24
  logic signed [35:0] vp14_q, vp24_q, vp13e_q, vp23e_q, vp12e_q, vp22e_q;
  // stage f: moment products
  logic signed [53:0] m4x_q, m4y_q, m3x_q, m3y_q, m2x_q, m2y_q;
  // stage g: sums
  logic signed [55:0] t4_q, t3_q, t2_q;

  logic signed [55:0] sa, sb, sc, sd;
  logic signed [55:0] t4_d, t3_d, t2_d;

  function automatic logic signed [31:0] sat_out(input logic signed [55:0] t);
    logic signed [55:0] r;
    r = (t + 56'sd16777216) >>> 25;
    if (r > 56'sd2147483647) sat_out = 32'sh7fffffff;
    else if (r < -56'sd2147483648) sat_out = 32'sh80000000;
    else sat_out = r[31:0];
  endfunction

  always_comb begin
    sa = (p1_q + p2_q + 56'sd32768) >>> 16;
    sb = (p3_q - p4_q + 56'sd32768) >>> 16;
    sc = (r1_q + r2_q + 56'sd32768) >>> 16;
    sd = (r3_q - r4_q + 56'sd32768) >>> 16;
    t4_d = 56'(m4x_q) - 56'(m4y_q);
    t3_d = 56'(m3x_q) - 56'(m3y_q);
    t2_d = 56'(m2x_q) - 56'(m2y_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vp12_q <= -($signed({1'b0, cfg_i.grav}) * s2_i);
      vp22_q <= -($signed({1'b0, cfg_i.grav}) * c2_i);
      s3a_q <= s3_i; c3a_q <= c3_i; s4a_q <= s4_i; c4a_q <= c4_i;

      p1_q <= c3a_q * vp12_q; p2_q <= s3a_q * vp22_q;
      p3_q <= c3a_q * vp22_q; p4_q <= s3a_q * vp12_q;
      vp12b_q <= vp12_q; vp22b_q <= vp22_q; s4b_q <= s4a_q; c4b_q <= c4a_q;

      vp13_q <= sa[35:0]; vp23_q <= sb[35:0];
      vp12c_q <= vp12b_q; vp22c_q <= vp22b_q; s4c_q <= s4b_q; c4c_q <= c4b_q;

      r1_q <= c4c_q * vp13_q; r2_q <= s4c_q * vp23_q;
      r3_q <= c4c_q * vp23_q; r4_q <= s4c_q * vp13_q;
      vp13d_q <= vp13_q; vp23d_q <= vp23_q; vp12d_q <= vp12c_q; vp22d_q <= vp22c_q;

      vp14_q <= sc[35:0]; vp24_q <= sd[35:0];
      vp13e_q <= vp13d_q; vp23e_q <= vp23d_q; vp12e_q <= vp12d_q; vp22e_q <= vp22d_q;

      m4x_q <= cfg_i.mx4 * vp24_q;  m4y_q <= cfg_i.my4 * vp14_q;
      m3x_q <= cfg_i.mx3 * vp23e_q; m3y_q <= cfg_i.my3 * vp13e_q;
      m2x_q <= cfg_i.mx2 * vp22e_q; m2y_q <= cfg_i.my2 * vp12e_q;

      t4_q <= t4_d;
      t3_q <= t4_d + t3_d;
      t2_q <= t4_d + t3_d + t2_d;
    end
  end

  always_comb begin
    out_o.torque_joint2 = sat_out(t2_q);
    out_o.torque_joint3 = sat_out(t3_q);
    out_o.torque_joint4 = sat_out(t4_q);
  end

endmodule

/* src/arm_gravity_torque_core.sv */
// Gravity-holding torques for joints 2..4 from the three joint angles. One angle
// set per cycle is accepted unless the output stalls; a result passes through
// the range reduction register, TrigStages cordic stages, seven rotation/torque
// stages and the output register. The whole pipeline halts while the output
// stalls. Configure registers only while the pipeline is empty.
module arm_gravity_torque_core import agt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  agt_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output agt_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned Depth = TrigStages + 9;

  agt_cfg_t cfg_q;
  logic [Depth-1:0] vld_q;
  logic en;
  logic signed [17:0] s2, c2, s3n, c3, s4, c4;
  agt_out_t res;

  assign cfg_ready_o = 1'b1;
  // advance unless the finished result is held
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{grav: 16'd40223, default: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRAVITY: cfg_q.grav <= cfg_data_i;
        REG_MX2:     cfg_q.mx2  <= cfg_data_i;
        REG_MY2:     cfg_q.my2  <= cfg_data_i;
        REG_MX3:     cfg_q.mx3  <= cfg_data_i;
        REG_MY3:     cfg_q.my3  <= cfg_data_i;
        REG_MX4:     cfg_q.mx4  <= cfg_data_i;
        REG_MY4:     cfg_q.my4  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  agt_trig u_trig2 (.clk_i, .en_i(en),
    .arg_i(Ofs2Q12 - 18'(in_data_i.angle_joint2)), .sin_o(s2), .cos_o(c2));
  agt_trig u_trig3 (.clk_i, .en_i(en),
    .arg_i(Ofs3Q12 + 18'(in_data_i.angle_joint3)), .sin_o(s3n), .cos_o(c3));
  agt_trig u_trig4 (.clk_i, .en_i(en),
    .arg_i(Ofs4Q12 - 18'(in_data_i.angle_joint4)), .sin_o(s4), .cos_o(c4));

  agt_chain u_chain (.clk_i, .en_i(en), .cfg_i(cfg_q),
    .s2_i(s2), .c2_i(c2), .s3_i(-s3n), .c3_i(c3), .s4_i(s4), .c4_i(c4),
    .out_o(res));

  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= res;
  end

  assign out_valid_o = vld_q[Depth-1];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall mismatch");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> $stable(vld_q[Depth-2:0]) || vld_q[0] == $past(in_valid_i))
    else $error("valid bit lost");

endmodule

/* sim/tb.sv */
module tb;
  import agt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = TrigStages + 9;
  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  agt_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  agt_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int  fail_count = 0;
  int  idle_pct = 26;
  longint cycles = 0;

  arm_gravity_torque_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  // arithmetic shift with floor, as used in the cordic steps
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void cordic_sin_cos(input longint arg_q12, output longint s,
                                         output longint c);
    longint a, x, y, nx;
    longint tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                        4193963, 2097109, 1048571, 524287, 262144, 131072,
                        65536, 32768, 16384, 8192, 4096, 2048,
                        1024, 512, 256, 128, 64, 32};
    bit flip;
    int n;
    a = arg_q12 * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    n = (TrigStages > 24) ? 24 : TrigStages;
    while (a > 843314857) a -= 1686629713;
    while (a < -843314857) a += 1686629713;
    if (a > 421657428) begin
      a -= 843314857;
      flip = 1;
    end else if (a < -421657428) begin
      a += 843314857;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (a >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        a -= tab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        a += tab[i];
      end
      x = nx;
    end
    c = round_q(x, 14);
    s = round_q(y, 14);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic logic signed [31:0] sat_torque(input longint t_q41);
    longint t;
    t = round_q(t_q41, 25);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  class torque_scoreboard;
    agt_cfg_t cfg;
    agt_out_t pending[$];

    function void load_reset();
      cfg = '0;
      cfg.grav = 16'd40223;
    endfunction

    function void write_reg(input reg_idx_e idx, input logic [15:0] val);
      case (idx)
        REG_GRAVITY: cfg.grav = val;
        REG_MX2:     cfg.mx2 = val;
        REG_MY2:     cfg.my2 = val;
        REG_MX3:     cfg.mx3 = val;
        REG_MY3:     cfg.my3 = val;
        REG_MX4:     cfg.mx4 = val;
        REG_MY4:     cfg.my4 = val;
        default: ;
      endcase
    endfunction

    function void note_angles(input agt_in_t a);
      longint s2, c2, s3, c3, s4, c4, g;
      longint vp12, vp22, vp13, vp23, vp14, vp24, t2, t3, t4;
      agt_out_t r;
      g = longint'({1'b0, cfg.grav});
      cordic_sin_cos(11078 - longint'(a.angle_joint2), s2, c2);
      cordic_sin_cos(10437 + longint'(a.angle_joint3), s3, c3);
      s3 = -s3;
      cordic_sin_cos(7327 - longint'(a.angle_joint4), s4, c4);
      vp12 = -(g * s2);
      vp22 = -(g * c2);
      vp13 = round_q(c3 * vp12 + s3 * vp22, 16);
      vp23 = round_q(c3 * vp22 - s3 * vp12, 16);
      vp14 = round_q(c4 * vp13 + s4 * vp23, 16);
      vp24 = round_q(c4 * vp23 - s4 * vp13, 16);
      t4 = longint'(cfg.mx4) * vp24 - longint'(cfg.my4) * vp14;
      t3 = t4 + longint'(cfg.mx3) * vp23 - longint'(cfg.my3) * vp13;
      t2 = t3 + longint'(cfg.mx2) * vp22 - longint'(cfg.my2) * vp12;
      r.torque_joint2 = sat_torque(t2);
      r.torque_joint3 = sat_torque(t3);
      r.torque_joint4 = sat_torque(t4);
      pending.push_back(r);
    endfunction

    task check_torques(input agt_out_t got);
      agt_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.torque_joint2 !== want.torque_joint2)
        report_mismatch($sformatf("torque_joint2 got %0d want %0d",
                                  got.torque_joint2, want.torque_joint2));
      if (got.torque_joint3 !== want.torque_joint3)
        report_mismatch($sformatf("torque_joint3 got %0d want %0d",
                                  got.torque_joint3, want.torque_joint3));
      if (got.torque_joint4 !== want.torque_joint4)
        report_mismatch($sformatf("torque_joint4 got %0d want %0d",
                                  got.torque_joint4, want.torque_joint4));
    endtask
  endclass

  torque_scoreboard torques = new();

  function automatic bit idle_now();
    return $urandom_range(99) < idle_pct;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) torques.check_torques(out_data_o);
      out_stall_i <= idle_now();
    end
  end

  // valid stays high after the transfer; idle gaps and drain drop it
  task automatic send_angles(input agt_in_t a);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    torques.note_angles(a);
  endtask

  task automatic write_cfg(input reg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    torques.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (torques.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic agt_in_t random_angles();
    agt_in_t a;
    a.angle_joint2 = pick_word();
    a.angle_joint3 = pick_word();
    a.angle_joint4 = pick_word();
    return a;
  endfunction

  task automatic set_all(input logic [15:0] g, input logic [15:0] m[6]);
    write_cfg(REG_GRAVITY, g);
    write_cfg(REG_MX2, m[0]);
    write_cfg(REG_MY2, m[1]);
    write_cfg(REG_MX3, m[2]);
    write_cfg(REG_MY3, m[3]);
    write_cfg(REG_MX4, m[4]);
    write_cfg(REG_MY4, m[5]);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] m[6];
    logic [15:0] g;
    agt_in_t a;
    torques.load_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers give zero torque; two angles before any write
    a = '0;
    send_angles(a);
    a = '{16'sh7fff, 16'sh8000, 16'sh7fff};
    send_angles(a);
    drain();

    m = '{16'd4096, -16'sd2048, 16'd3000, 16'd1500, -16'sd800, 16'd700};
    set_all(16'd40223, m);
    // directed: field extremes, offsets cancelling, wrap beyond pi
    send_angles('{16'sh0000, 16'sh0000, 16'sh0000});
    send_angles('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_angles('{16'sh8000, 16'sh8000, 16'sh8000});
    send_angles('{16'sd11078, -16'sd10437, 16'sd7327});
    send_angles('{16'shffff, 16'sh0001, 16'shffff});
    send_angles('{16'sd12868, -16'sd12868, 16'sd6434});
    send_angles('{-16'sd6434, 16'sd25736, -16'sd25736});
    drain();

    // extreme settings, including the saturation corner, then random settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin g = 16'hffff; foreach (m[k]) m[k] = 16'h7fff; end
        1: begin g = 16'hffff; foreach (m[k]) m[k] = 16'h8000; end
        2: begin g = 16'h0000; foreach (m[k]) m[k] = 16'h7fff; end
        3: begin g = 16'hffff; foreach (m[k]) m[k] = k[0] ? 16'h8000 : 16'h7fff; end
        default: begin
          g = pick_word();
          foreach (m[k]) m[k] = pick_word();
        end
      endcase
      set_all(g, m);
      idle_pct = (phase == 5) ? 0 : 26;
      for (int n = 0; n < ((phase < 4) ? 60 : 400); n++) send_angles(random_angles());
      drain();
    end
    // unknown register index is ignored
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 3'd7;
    cfg_data_i <= 16'h1234;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    for (int n = 0; n < 40; n++) send_angles(random_angles());
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
